// ===== src/rlem_pkg.sv =====
package rlem_pkg;

  localparam int LANES       = 8;
  localparam int LENGTH_BITS = 16;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int NSLOT       = LANES + 1;

  localparam logic [LENGTH_BITS-1:0] MAX_LEN = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [LANES*BYTE_W-1:0] symbol_group;
    logic [CNT_W-1:0]        lane_count;
    logic                    end_of_stream;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      run_symbol;
    logic [LENGTH_BITS-1:0] run_length;
    logic                   final_run;
  } out_t;

  // per-lane status: lane in range, and byte breaks the run it follows
  typedef struct packed {
    logic valid;
    logic brk;
  } lane_stat_t;

endpackage

// ===== src/rlem_lane.sv =====
module rlem_lane import rlem_pkg::*; (
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] prev_i,
  input  logic              prev_ok_i,
  input  logic [CNT_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output lane_stat_t        stat_o
);

  // prev_ok_i low means nothing precedes this lane: it always starts a run
  always_comb begin
    stat_o.valid = (idx_i < cnt_i);
    stat_o.brk   = !prev_ok_i || (byte_i != prev_i);
  end

endmodule

// ===== src/rlem_merge.sv =====
module rlem_merge import rlem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  in_t                   data_i,
  input  lane_stat_t [LANES-1:0] stat_i,
  output logic [BYTE_W-1:0]     held_sym_o,
  output logic                  held_open_o,
  output out_t [NSLOT-1:0]      slot_o,
  output logic [NSLOT-1:0]      mask_o
);

  logic [BYTE_W-1:0]      held_sym_q, held_sym_d;
  logic [LENGTH_BITS-1:0] held_len_q, held_len_d;
  logic                   open_q, open_d;

  logic [CNT_W-1:0]       cnt_sat;
  logic                   cont;
  logic                   split;
  logic [CNT_W-1:0]       first_len;
  logic [LENGTH_BITS:0]   first_sum;
  logic [LENGTH_BITS-1:0] base;
  logic [LENGTH_BITS-1:0] end_len [LANES];
  logic [BYTE_W-1:0]      new_sym;
  logic [LENGTH_BITS-1:0] new_len;
  logic                   new_open;

  assign held_sym_o  = held_sym_q;
  assign held_open_o = open_q;

  always_comb begin
    logic [CNT_W-1:0] st;
    logic             fst;

    cnt_sat = (data_i.lane_count > CNT_W'(LANES)) ? CNT_W'(LANES) : data_i.lane_count;
    cont    = stat_i[0].valid && !stat_i[0].brk;

    // length of the leading run inside this transaction
    first_len = cnt_sat;
    for (int k = LANES - 1; k >= 1; k--) begin
      if (stat_i[k].valid && stat_i[k].brk) first_len = CNT_W'(k);
    end
    first_sum = {1'b0, held_len_q} + (LENGTH_BITS+1)'(first_len);
    split     = cont && (first_sum > {1'b0, MAX_LEN});
    // carried part of the leading run; wraps, final sums land in range
    base = (cont ? held_len_q : '0) - (split ? MAX_LEN : '0);

    // length of the run ending at each lane
    for (int j = 0; j < LANES; j++) begin
      st  = '0;
      fst = 1'b1;
      for (int i = 1; i < LANES; i++) begin
        if (i <= j && stat_i[i].brk) begin
          st  = CNT_W'(i);
          fst = 1'b0;
        end
      end
      end_len[j] = (fst ? base : '0) + LENGTH_BITS'(CNT_W'(j) - st + CNT_W'(1));
    end

    // slot 0: held run closed by lane 0, or a full run split off
    mask_o[0]            = (open_q && stat_i[0].valid && stat_i[0].brk) || split;
    slot_o[0].run_symbol = held_sym_q;
    slot_o[0].run_length = split ? MAX_LEN : held_len_q;
    slot_o[0].final_run  = 1'b0;

    for (int k = 1; k < LANES; k++) begin
      mask_o[k]            = stat_i[k].valid && stat_i[k].brk;
      slot_o[k].run_symbol = data_i.symbol_group[BYTE_W*(k-1) +: BYTE_W];
      slot_o[k].run_length = end_len[k-1];
      slot_o[k].final_run  = 1'b0;
    end

    new_sym  = held_sym_q;
    new_len  = held_len_q;
    new_open = open_q;
    for (int k = 0; k < LANES; k++) begin
      if (CNT_W'(k + 1) == cnt_sat) begin
        new_sym  = data_i.symbol_group[BYTE_W*k +: BYTE_W];
        new_len  = end_len[k];
        new_open = 1'b1;
      end
    end

    mask_o[LANES]            = data_i.end_of_stream && new_open;
    slot_o[LANES].run_symbol = new_sym;
    slot_o[LANES].run_length = new_len;
    slot_o[LANES].final_run  = 1'b1;

    if (data_i.end_of_stream) begin
      held_sym_d = '0;
      held_len_d = '0;
      open_d     = 1'b0;
    end else begin
      held_sym_d = new_sym;
      held_len_d = new_len;
      open_d     = new_open;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_sym_q <= '0;
      held_len_q <= '0;
      open_q     <= 1'b0;
    end else if (accept_i) begin
      held_sym_q <= held_sym_d;
      held_len_q <= held_len_d;
      open_q     <= open_d;
    end
  end

endmodule

// ===== src/rlem_drain.sv =====
module rlem_drain import rlem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  out_t [NSLOT-1:0] slot_i,
  input  logic [NSLOT-1:0] mask_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_t             out_data_o,
  output logic             can_load_o
);

  logic [NSLOT-1:0] mask_q, mask_d;
  out_t [NSLOT-1:0] slot_q;
  logic [NSLOT-1:0] sel;
  logic             take;

  assign sel         = mask_q & (~mask_q + NSLOT'(1));
  assign out_valid_o = |mask_q;
  assign take        = out_valid_o && out_ready_i;
  // free when empty, or when the last pending run leaves this cycle
  assign can_load_o  = (mask_q == '0) || ((mask_q == sel) && out_ready_i);

  always_comb begin
    out_data_o = '0;
    for (int s = 0; s < NSLOT; s++) begin
      if (sel[s]) out_data_o = out_t'(out_data_o | slot_q[s]);
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (take) mask_d = mask_q & ~sel;
    if (load_i) mask_d = mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) slot_q <= slot_i;
  end

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (mask_i != '0)) |=> out_valid_o)
    else $error("loaded runs not presented");

  a_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_i |=> ((mask_q & ~$past(mask_q)) == '0))
    else $error("pending mask grew without a load");

  a_load_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (can_load_o && (mask_q != '0)) |-> ($onehot(mask_q) && out_ready_i))
    else $error("load allowed with runs still pending");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !load_i) |=> ($countones(mask_q) == $countones($past(mask_q)) - 1))
    else $error("taken run not retired");

endmodule

// ===== src/run_length_encoder_multi_lane_top.sv =====
// Multi-lane run-length encoder.
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction carries
// up to LANES bytes, lane 0 first, a lane count and an end-of-stream flag.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction is
// one finished run (symbol, length); final_run marks the flush at end of stream.
// Runs join across lanes and across input transactions; a run that would pass
// 2^LENGTH_BITS - 1 is sent at that length and the rest starts a fresh run.
// An accepted input's runs are registered in the drain stage and are presented
// on the output channel after the accepting edge.
// Throughput: one input per cycle while each input closes at most one run and
// the output is ready. An input that closes more runs holds the input side until
// they are sent: the drain stage sends one run per cycle while out_ready_i is
// high, and the next input is taken in the same cycle the last pending run leaves.
// Reset: no run held, no runs pending, in_ready_o high.
// Output stall: pending runs wait in the drain registers with payload held;
// in_ready_o stays low until they are gone.
module run_length_encoder_multi_lane_top import rlem_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  lane_stat_t [LANES-1:0] stat;
  logic [BYTE_W-1:0]      held_sym;
  logic                   held_open;
  out_t [NSLOT-1:0]       slot;
  logic [NSLOT-1:0]       mask;
  logic                   can_load;
  logic                   accept;
  logic [CNT_W-1:0]       cnt_sat;

  assign cnt_sat = (in_data_i.lane_count > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                          : in_data_i.lane_count;
  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;

  // lane 0 compares against the held run, the others against their left neighbor
  rlem_lane u_lane0 (
    .byte_i    (in_data_i.symbol_group[BYTE_W-1:0]),
    .prev_i    (held_sym),
    .prev_ok_i (held_open),
    .idx_i     (CNT_W'(0)),
    .cnt_i     (cnt_sat),
    .stat_o    (stat[0])
  );

  for (genvar k = 1; k < LANES; k++) begin : g_lane
    rlem_lane u_lane (
      .byte_i    (in_data_i.symbol_group[BYTE_W*k +: BYTE_W]),
      .prev_i    (in_data_i.symbol_group[BYTE_W*(k-1) +: BYTE_W]),
      .prev_ok_i (1'b1),
      .idx_i     (CNT_W'(k)),
      .cnt_i     (cnt_sat),
      .stat_o    (stat[k])
    );
  end

  // merges lane breaks with the held run into up to LANES+1 run slots
  rlem_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_i      (in_data_i),
    .stat_i      (stat),
    .held_sym_o  (held_sym),
    .held_open_o (held_open),
    .slot_o      (slot),
    .mask_o      (mask)
  );

  // registers the slots and sends them in stream order, one per cycle while out_ready_i is high
  rlem_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .slot_i      (slot),
    .mask_i      (mask),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .can_load_o  (can_load)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the multi-lane run-length encoder.
// A directed table runs first, then random byte streams. Each accepted input
// transaction feeds a local encoder that queues the runs it closes; each run
// on the output channel is checked against the oldest queued run.
module tb_top;
  import rlem_pkg::*;

  localparam int RAND_GROUPS  = 420;   // random input transactions
  localparam int CALM_GROUPS  = 60;    // tail of the random part with no idling
  localparam int HOLD_CYCLES  = 150;   // one long output stall to back up the input
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 20;    // settle time after the last expected run

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i     = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #5 clk_i = ~clk_i;

  run_length_encoder_multi_lane_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // --------------------------------------------------------------------------
  // Shared state between stimulus, receiver and checker
  // --------------------------------------------------------------------------
  out_t pending_runs[$];   // runs the local encoder says must come out, oldest first

  // local encoder state: the run still open across lanes and transactions
  logic [BYTE_W-1:0]      open_sym  = '0;
  logic [LENGTH_BITS-1:0] open_len  = '0;
  logic                   open_live = 1'b0;

  logic [BYTE_W-1:0] prev_byte = '0;  // last random byte, biases streams toward runs

  bit calm      = 1'b0;  // no idling on either side
  bit quiet     = 1'b0;  // sender skips gaps for the current block of transactions
  bit hold_req  = 1'b0;  // sender asks the receiver for the long stall
  bit long_hold = 1'b0;  // receiver is in the long stall

  int groups_sent  = 0;
  int runs_checked = 0;
  int flush_runs   = 0;
  int longest_run  = 0;
  int mismatches   = 0;

  // --------------------------------------------------------------------------
  // Local encoder: walks the valid lanes of one transaction in stream order.
  // A lane count above LANES is clamped. A full run is closed when one more
  // equal byte arrives, and that byte opens a fresh run. End of stream flushes
  // whatever is held and clears the state. keep = 0 updates the state only.
  // --------------------------------------------------------------------------
  function automatic void encode_group(input in_t g, input bit keep);
    int unsigned       lanes;
    logic [BYTE_W-1:0] b;
    lanes = (g.lane_count > LANES) ? LANES : g.lane_count;
    for (int k = 0; k < lanes; k++) begin
      b = g.symbol_group[BYTE_W*k +: BYTE_W];
      if (open_live && b == open_sym && open_len < MAX_LEN) begin
        open_len++;
      end else begin
        if (open_live && keep)
          pending_runs.push_back('{run_symbol: open_sym, run_length: open_len,
                                   final_run: 1'b0});
        open_sym  = b;
        open_len  = LENGTH_BITS'(1);
        open_live = 1'b1;
      end
    end
    if (g.end_of_stream) begin
      if (open_live && keep)
        pending_runs.push_back('{run_symbol: open_sym, run_length: open_len,
                                 final_run: 1'b1});
      open_sym  = '0;
      open_len  = '0;
      open_live = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random transaction: mostly repeats of the previous byte, a few favorite
  // symbols, some noise. Lane count mostly full, sometimes short, now and then
  // anything the 4-bit field holds (zero and above LANES included).
  // --------------------------------------------------------------------------
  function automatic in_t rand_group();
    in_t         g;
    int unsigned pick;
    int          k;
    for (k = 0; k < LANES; k++) begin
      pick = $urandom_range(0, 9);
      if (pick >= 8)
        prev_byte = BYTE_W'($urandom_range(0, 255));
      else if (pick >= 5) begin
        case ($urandom_range(0, 2))
          0:       prev_byte = 8'h00;
          1:       prev_byte = 8'hFF;
          default: prev_byte = 8'h5A;
        endcase
      end
      g.symbol_group[BYTE_W*k +: BYTE_W] = prev_byte;
    end
    pick = $urandom_range(0, 9);
    if (pick < 6)
      g.lane_count = CNT_W'(LANES);
    else if (pick < 9)
      g.lane_count = CNT_W'($urandom_range(1, LANES - 1));
    else
      g.lane_count = CNT_W'($urandom_range(0, 15));
    g.end_of_stream = ($urandom_range(0, 7) == 0);
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional gap, then hold valid and payload until the transaction is
  // taken. Handshake is sampled at the falling edge, where everything driven at
  // the rising edge has settled, so the check never races the DUT's flops.
  // Returns right after the accepting rising edge.
  // --------------------------------------------------------------------------
  task automatic send_group(input in_t g);
    bit took;
    if (groups_sent % 32 == 0)
      quiet = ($urandom_range(0, 2) == 0);
    if (!calm && !quiet && !hold_req && !long_hold && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= g;
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
    groups_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Rows marked typed carry the run read straight off the
  // encoding rules; the rest go through the local encoder. reps repeats a row.
  // --------------------------------------------------------------------------
  typedef struct {
    in_t  grp;
    int   reps;
    bit   typed;
    bit   has_run;
    out_t run;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void add_row(input logic [LANES*BYTE_W-1:0] bytes, input int cnt,
                                  input bit eos, input int reps, input bit typed,
                                  input bit has_run, input out_t run);
    plan_row_t row;
    row.grp.symbol_group  = bytes;
    row.grp.lane_count    = cnt[CNT_W-1:0];
    row.grp.end_of_stream = eos;
    row.reps              = reps;
    row.typed             = typed;
    row.has_run           = has_run;
    row.run               = run;
    plan.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_t g;
    int  directed_groups;

    // end of stream with nothing held, and no lanes: no run at all
    add_row(64'h0, 0, 1'b1, 1, 1'b1, 1'b0, '0);
    // single zero byte, flushed at once
    add_row(64'h0, 1, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'h00, run_length: 16'd1, final_run: 1'b1});
    // all ones, full lanes
    add_row({8{8'hFF}}, LANES, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'hFF, run_length: 16'd8, final_run: 1'b1});
    // no lanes, no end: payload ignored
    add_row(64'hA5A5_5A5A_C3C3_3C3C, 0, 1'b0, 1, 1'b1, 1'b0, '0);
    // lane count 15 clamps to LANES; every lane differs
    add_row(64'h0102_0304_0506_0708, 15, 1'b0, 1, 1'b0, 1'b0, '0);
    // flush with no lanes: held lane-7 byte comes out alone
    add_row(64'h0, 0, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'h01, run_length: 16'd1, final_run: 1'b1});
    // bytes above the lane count are ignored
    add_row(64'h1234_5678_9A55_5555, 3, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'h55, run_length: 16'd3, final_run: 1'b1});
    // run carried across transactions, then a group that closes LANES+1 runs
    add_row({8{8'hFF}}, LANES, 1'b0, 1, 1'b0, 1'b0, '0);
    add_row({8{8'hFF}}, 4, 1'b0, 1, 1'b0, 1'b0, '0);
    add_row(64'h0807_0605_0403_0201, LANES, 1'b1, 1, 1'b0, 1'b0, '0);
    // alternating bytes, then lane count 9 clamped, with flush
    add_row(64'h00FF_00FF_00FF_00FF, LANES, 1'b0, 1, 1'b0, 1'b0, '0);
    add_row(64'h0, 9, 1'b1, 1, 1'b0, 1'b0, '0);
    // lane count 12 clamps to LANES
    add_row({8{8'h11}}, 12, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'h11, run_length: 16'd8, final_run: 1'b1});
    // one byte past a full run: full run sent, a fresh run of one is held
    add_row({8{8'hAA}}, LANES, 1'b0, (1 << LENGTH_BITS) / LANES, 1'b0, 1'b0, '0);
    add_row(64'h0, 0, 1'b1, 1, 1'b1, 1'b1,
            '{run_symbol: 8'hAA, run_length: 16'd1, final_run: 1'b1});
    // run of exactly the maximum, closed by a different byte
    add_row({8{8'hAA}}, LANES, 1'b0, (1 << LENGTH_BITS) / LANES - 1, 1'b0, 1'b0, '0);
    add_row({8{8'hAA}}, LANES - 1, 1'b0, 1, 1'b0, 1'b0, '0);
    add_row(64'h0000_0000_0000_0055, 1, 1'b1, 1, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        send_group(plan[r].grp);
        encode_group(plan[r].grp, !plan[r].typed);
      end
      if (plan[r].typed && plan[r].has_run)
        pending_runs.push_back(plan[r].run);
    end
    directed_groups = groups_sent;

    // random streams; one long output stall a third of the way in
    for (int i = 0; i < RAND_GROUPS; i++) begin
      calm = (i >= RAND_GROUPS - CALM_GROUPS);
      if (i == RAND_GROUPS / 3)
        hold_req = 1'b1;
      g = rand_group();
      if (i == RAND_GROUPS - 1)
        g.end_of_stream = 1'b1;
      send_group(g);
      encode_group(g, 1'b1);
    end
    in_valid <= 1'b0;

    // watchdog covers a run that never shows up
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d input transactions (%0d directed), %0d runs checked, %0d flushes,",
             groups_sent, directed_groups, runs_checked, flush_runs);
    $display("         longest run %0d, one %0d-cycle output stall, %0d mismatches",
             longest_run, HOLD_CYCLES, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts and ready stretches; the long stall when the
  // sender asks for it; always ready in the calm tail.
  // --------------------------------------------------------------------------
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24) - 1) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run checker: sampled at the falling edge, the transaction completes at the
  // next rising edge. Compared field by field with the oldest pending run.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_runs
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      runs_checked++;
      if (out_data.final_run)
        flush_runs++;
      if (out_data.run_length > longest_run)
        longest_run = out_data.run_length;
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected run sym %02h len %0d final %0b", $realtime,
                   out_data.run_symbol, out_data.run_length, out_data.final_run);
      end else begin
        want = pending_runs.pop_front();
        if (out_data.run_symbol !== want.run_symbol ||
            out_data.run_length !== want.run_length ||
            out_data.final_run  !== want.final_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: run %0d exp sym %02h len %0d final %0b, got sym %02h len %0d final %0b",
                     $realtime, runs_checked, want.run_symbol, want.run_length,
                     want.final_run, out_data.run_symbol, out_data.run_length,
                     out_data.final_run);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no transaction on either channel.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk_i);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: timeout, no transaction for %0d cycles, %0d runs still pending",
             $realtime, IDLE_LIMIT, pending_runs.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
